FILE: src/svfu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svfu_pkg
// Shared types, opcodes and address decode for the script variable flag unit.
// ----------------------------------------------------------------------------
package svfu_pkg;

	localparam int VarDepth  = 672;
	localparam int FlagDepth = 428;
	localparam int VarAw     = 10;
	localparam int FlagAw    = 9;

	typedef enum logic [4:0] {
		CMD_READ   = 5'd0,
		CMD_SETVI  = 5'd1,
		CMD_SETVV  = 5'd2,
		CMD_CSETVI = 5'd3,
		CMD_CSETVV = 5'd4,
		CMD_CMPVI  = 5'd5,
		CMD_CMPVV  = 5'd6,
		CMD_ADDVI  = 5'd7,
		CMD_ADDVV  = 5'd8,
		CMD_SUBVI  = 5'd9,
		CMD_SUBVV  = 5'd10,
		CMD_LDFLG  = 5'd11,
		CMD_STFLG  = 5'd12,
		CMD_SWAPZN = 5'd13,
		CMD_LUT2   = 5'd14,
		CMD_LUT3   = 5'd15,
		CMD_LUT4   = 5'd16,
		CMD_JMP    = 5'd17,
		CMD_JZ     = 5'd18,
		CMD_JNZ    = 5'd19,
		CMD_JN     = 5'd20,
		CMD_JP     = 5'd21,
		CMD_JLE    = 5'd22,
		CMD_JG     = 5'd23
	} cmd_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_EXEC
	} state_t;

	typedef struct packed {
		logic [4:0]  command;
		logic [11:0] first_addr;
		logic [15:0] second_operand;
		logic [15:0] t0;
		logic [15:0] t1;
		logic [15:0] t2;
		logic [15:0] t3;
	} item_t;

	typedef struct packed {
		logic              ok;
		logic [VarAw-1:0]  slot;
	} vslot_t;

	typedef struct packed {
		logic              ok;
		logic [FlagAw-1:0] byte_idx;
		logic [2:0]        bit_idx;
	} fslot_t;

	function automatic vslot_t var_slot(input logic [15:0] a);
		vslot_t r;
		logic [15:0] s;
		r = '0;
		s = '0;
		if (a < 16'h0020) begin
			r.ok = 1'b1; s = a;
		end else if (a >= 16'h0080 && a < 16'h0100) begin
			r.ok = 1'b1; s = a - 16'h0080 + 16'd32;
		end else if (a >= 16'h0400 && a < 16'h0600) begin
			r.ok = 1'b1; s = a - 16'h0400 + 16'd160;
		end
		r.slot = s[VarAw-1:0];
		return r;
	endfunction

	function automatic fslot_t flag_slot(input logic [11:0] a);
		fslot_t r;
		logic [11:0] f;
		r = '0;
		f = '0;
		if (a >= 12'h020 && a < 12'h080) begin
			r.ok = 1'b1; f = a - 12'h020;
		end else if (a >= 12'h100 && a < 12'h400) begin
			r.ok = 1'b1; f = a - 12'h100 + 12'd96;
		end else if (a >= 12'h600) begin
			r.ok = 1'b1; f = a - 12'h600 + 12'd864;
		end
		r.byte_idx = f[11:3];
		r.bit_idx  = f[2:0];
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: src/svfu_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svfu_front
// Two-entry item queue between the input port and the execution engine.
// ----------------------------------------------------------------------------
module svfu_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	output logic                full,
	input  svfu_pkg::item_t     in_item,
	output logic                avail,
	input  wire                 take,
	output svfu_pkg::item_t     out_item
);
	import svfu_pkg::*;

	item_t      mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full     = cnt_q == 2'd2;
	assign avail    = cnt_q != 2'd0;
	assign out_item = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wp_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) wp_q <= ~wp_q;
			if (take && avail) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push && !full) - 2'(take && avail);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'd2) else $error("queue count overflow");
	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		full && !(take && avail) |=> full) else $error("full dropped without take");
	a_take_avail: assert property (@(posedge clk) disable iff (!arst_n)
		!avail && !(push && !full) |=> !avail) else $error("item appeared");

endmodule
`default_nettype wire

FILE: src/svfu_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svfu_back
// Execution engine: clears stores after reset, reads operands, writes back and
// holds one result for the output side.
// ----------------------------------------------------------------------------
module svfu_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 avail,
	output logic                take,
	input  svfu_pkg::item_t     item,
	output logic                empty,
	input  wire                 pop,
	output logic                branch_taken,
	output logic                zero_flag,
	output logic                negative_flag,
	output logic signed [15:0]  variable_value,
	output logic                bad_address
);
	import svfu_pkg::*;

	logic [15:0] vmem [VarDepth];
	logic [7:0]  fmem [FlagDepth];

	state_t state_q, state_d;
	logic [VarAw-1:0] clr_q;
	logic   z_q, n_q, res_v_q;
	item_t  it_q;
	logic [15:0] a_rd_q, b_rd_q;
	logic [7:0]  f_rd_q;

	vslot_t va, vb;
	fslot_t fa;
	cmd_t   cmd;
	logic   clr_done;
	logic   out_free;

	assign cmd = cmd_t'(it_q.command);
	assign va  = var_slot({4'd0, it_q.first_addr});
	assign vb  = var_slot(it_q.second_operand);
	assign fa  = flag_slot(it_q.first_addr);
	assign clr_done = clr_q == VarAw'(VarDepth - 1);
	assign empty = !res_v_q;
	// result register is free now or is being popped at this edge
	assign out_free = !res_v_q || pop;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (clr_done) state_d = ST_IDLE;
			ST_IDLE:  if (avail && out_free) state_d = ST_READ;
			ST_READ:  state_d = ST_EXEC;
			ST_EXEC:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		take = state_q == ST_IDLE && avail && out_free;
	end

	logic [15:0] a, b, r, wv;
	logic        bad, we_v, we_f, z_d, n_d, tk;
	logic [7:0]  fw;
	always_comb begin
		a = va.ok ? a_rd_q : 16'd0;
		b = vb.ok ? b_rd_q : 16'd0;
		bad = 1'b0; we_v = 1'b0; we_f = 1'b0; tk = 1'b0;
		z_d = z_q; n_d = n_q; wv = '0; r = '0;
		fw = f_rd_q;
		case (cmd)
			CMD_SETVI, CMD_SETVV, CMD_CSETVI, CMD_CSETVV: begin
				if (!(cmd == CMD_CSETVI || cmd == CMD_CSETVV) || z_q) begin
					if (cmd == CMD_SETVV || cmd == CMD_CSETVV) begin
						wv = b; bad = !vb.ok;
					end else begin
						wv = it_q.second_operand;
					end
					we_v = va.ok;
					if (!va.ok) bad = 1'b1;
				end
			end
			CMD_CMPVI, CMD_CMPVV: begin
				r = (cmd == CMD_CMPVI) ? it_q.second_operand : b;
				if (cmd == CMD_CMPVV && !vb.ok) bad = 1'b1;
				if (!va.ok) bad = 1'b1;
				z_d = a == r;
				n_d = $signed(a) < $signed(r);
			end
			CMD_ADDVI, CMD_ADDVV, CMD_SUBVI, CMD_SUBVV: begin
				r = (cmd == CMD_ADDVI || cmd == CMD_SUBVI) ? it_q.second_operand : b;
				if ((cmd == CMD_ADDVV || cmd == CMD_SUBVV) && !vb.ok) bad = 1'b1;
				if (!va.ok) bad = 1'b1;
				wv = (cmd == CMD_ADDVI || cmd == CMD_ADDVV) ? a + r : a - r;
				we_v = va.ok;
				z_d = wv == 16'd0;
				n_d = wv[15];
			end
			CMD_LDFLG: begin
				if (va.ok) z_d = a_rd_q != 16'd0;
				else if (fa.ok) z_d = f_rd_q[fa.bit_idx];
				else z_d = 1'b0;
			end
			CMD_STFLG: begin
				fw[fa.bit_idx] = z_q;
				we_f = fa.ok;
			end
			CMD_SWAPZN: begin
				z_d = n_q; n_d = z_q;
			end
			CMD_LUT2, CMD_LUT3, CMD_LUT4: begin
				if (a < (16'(cmd) - 16'd12)) begin
					case (a[1:0])
						2'd0: wv = it_q.t0;
						2'd1: wv = it_q.t1;
						2'd2: wv = it_q.t2;
						default: wv = it_q.t3;
					endcase
				end
				we_v = va.ok;
				if (!va.ok) bad = 1'b1;
			end
			CMD_JMP: tk = 1'b1;
			CMD_JZ:  tk = z_q;
			CMD_JNZ: tk = !z_q;
			CMD_JN:  tk = n_q;
			CMD_JP:  tk = !n_q;
			CMD_JLE: tk = z_q | n_q;
			CMD_JG:  tk = !(z_q | n_q);
			default: ;
		endcase
	end

	logic [15:0] val;
	always_comb begin
		if (we_v) val = wv;
		else if (va.ok) val = a_rd_q;
		else if (fa.ok) val = {15'd0, (we_f ? fw[fa.bit_idx] : f_rd_q[fa.bit_idx])};
		else val = 16'd0;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) begin
			vmem[clr_q] <= '0;
			if (clr_q < VarAw'(FlagDepth)) fmem[clr_q[FlagAw-1:0]] <= '0;
		end else if (state_q == ST_EXEC) begin
			if (we_v) vmem[va.slot] <= wv;
			if (we_f) fmem[fa.byte_idx] <= fw;
		end
		if (state_q == ST_READ) begin
			a_rd_q <= vmem[va.slot];
			b_rd_q <= vmem[vb.slot];
			f_rd_q <= fmem[fa.byte_idx];
		end
		if (take) it_q <= item;
		if (state_q == ST_EXEC) begin
			branch_taken   <= tk;
			variable_value <= val;
			bad_address    <= bad;
		end
	end

	assign zero_flag     = z_q;
	assign negative_flag = n_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			z_q     <= 1'b0;
			n_q     <= 1'b0;
			res_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + VarAw'(1);
			if (state_q == ST_EXEC) begin
				z_q <= z_d; n_q <= n_d; res_v_q <= 1'b1;
			end else if (pop && res_v_q) begin
				res_v_q <= 1'b0;
			end
		end
	end

	a_no_take_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !take) else $error("item taken during clear");
	a_exec_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |=> state_q == ST_EXEC) else $error("read not followed by exec");
	a_result_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EXEC |=> res_v_q) else $error("result lost");
	a_flags_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_EXEC |=> $stable(z_q) && $stable(n_q)) else $error("flags moved");

endmodule
`default_nettype wire

FILE: src/script_variable_flag_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// script_variable_flag_unit
// Data and branch instruction unit of a script engine over a 4096-entry map.
//
// Input side is a queue: drive the item fields with push while full is low.
// Result side is a queue: a result shows while empty is low, pop takes it.
// Each item gives exactly one result, in order.
// After reset the variable and flag stores are cleared in a pass over the 672
// variable slots; the front queue takes up to two items meanwhile, then full rises.
// An idle unit shows the result after the steps of queue pickup, store read,
// and execute and write back; one item is worked on at a time, so the engine
// takes no new item until the store read and write-back sequence of the last
// one is through.
// When pop stays low, the held result stops the engine, the front queue
// fills behind it and full rises; nothing is dropped.
// Z and N flags reset to zero.
// ----------------------------------------------------------------------------
module script_variable_flag_unit (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                push,
	output logic               full,
	input  wire  [4:0]         command,
	input  wire  [11:0]        first_addr,
	input  wire  [15:0]        second_operand,
	input  wire  signed [15:0] table_entry_zero,
	input  wire  signed [15:0] table_entry_one,
	input  wire  signed [15:0] table_entry_two,
	input  wire  signed [15:0] table_entry_three,
	output logic               empty,
	input  wire                pop,
	output logic               branch_taken,
	output logic               zero_flag,
	output logic               negative_flag,
	output logic signed [15:0] variable_value,
	output logic               bad_address
);
	import svfu_pkg::*;

	item_t in_item, q_item;
	logic  avail, take, q_full;

	assign in_item = '{command: command, first_addr: first_addr,
		second_operand: second_operand, t0: table_entry_zero,
		t1: table_entry_one, t2: table_entry_two, t3: table_entry_three};

	svfu_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(q_full),
		.in_item(in_item), .avail(avail), .take(take), .out_item(q_item)
	);

	assign full = q_full;

	svfu_back u_back (
		.clk(clk), .arst_n(arst_n), .avail(avail), .take(take), .item(q_item),
		.empty(empty), .pop(pop), .branch_taken(branch_taken),
		.zero_flag(zero_flag), .negative_flag(negative_flag),
		.variable_value(variable_value), .bad_address(bad_address)
	);

endmodule
`default_nettype wire
